FILE: rtl/core/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int FIELD_W  = 17;
  localparam int STATUS_W = 3;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_ZERO_OR_NULL = 3'd1,
    ST_NO_FIT       = 3'd2,
    ST_TABLE_FULL   = 3'd3,
    ST_UNKNOWN      = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic gt;
    logic eq;
    logic lt;
  } alu_flags_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_MOVE,
    S_A_SUB,
    S_A_HI,
    S_A_LO,
    S_F_RNEXT,
    S_F_CNEXT,
    S_F_HNEXT,
    S_F_RPREV,
    S_F_CPREV,
    S_F_HPREV,
    S_F_WR,
    S_RESULT
  } fsm_e;

endpackage

FILE: rtl/core/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ffsa_alu.sv
// ----------------------------------------------------------------------------
// ffsa_alu
// Shared add/subtract and magnitude compare unit of the allocator sequencer.
// ----------------------------------------------------------------------------
module ffsa_alu
  import ffsa_pkg::*;
#(
  parameter int W = 18
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output alu_flags_t   flags_o
);

  always_comb begin
    case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_SUB: res_o = a_i - b_i;
      default: res_o = a_i + b_i;
    endcase
    flags_o.gt = (a_i > b_i);
    flags_o.eq = (a_i == b_i);
    flags_o.lt = (a_i < b_i);
  end

endmodule

FILE: rtl/core/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit heap segment allocator with split on allocate and coalescing
// on free, built as a sequencer around one adder/comparator and a table RAM.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_stall_o is high from acceptance until the
// result is parked in the output register, and a new word may be taken while
// that result still waits. The segment table lives in a single RAM with one
// read and one write port, and that port sets the timing: the address-ordered
// scan reads one entry per cycle, an allocate whose hit is not the last entry
// shifts the table tail up one entry per cycle, and an allocate then writes
// the free remainder and the allocated entry; a free scans the same way, reads
// both neighbors where they exist, and each merge shifts the tail down one
// entry per cycle. Zero size or null words skip the scan and go straight to
// the result. After reset the block writes the initial whole-heap segment
// before it takes its first word.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32,
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [FIELD_W-1:0]  request_bytes_i,
  input  logic [FIELD_W-1:0]  release_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FIELD_W-1:0]  granted_offset_o,
  output logic [STATUS_W-1:0] status_o
);

  // datapath wide enough for offset + header and request + header
  localparam int DW = ($clog2(HEAP_BYTES) + 2 > FIELD_W + 1) ?
                      $clog2(HEAP_BYTES) + 2 : FIELD_W + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * DW + 1;

  localparam logic [DW-1:0] HDR  = DW'(HEADER_BYTES);
  localparam logic [DW-1:0] HEAP = DW'(HEAP_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

  fsm_e state_q, state_d, ret_q, ret_d;

  kind_e         kind_q, kind_d;
  logic [DW-1:0] req_q, req_d;
  logic [DW-1:0] key_q, key_d;
  logic [DW-1:0] cur_start_q, cur_start_d;
  logic [DW-1:0] cur_len_q, cur_len_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;

  logic [CW-1:0] scn_rd_q, scn_rd_d;
  logic          scn_vld_q, scn_vld_d;
  logic [IW-1:0] scn_idx_q, scn_idx_d;

  logic [IW-1:0] mv_rd_q, mv_rd_d;
  logic [IW-1:0] mv_end_q, mv_end_d;
  logic [IW-1:0] mv_wa_q, mv_wa_d;
  logic          mv_up_q, mv_up_d;
  logic          mv_iss_q, mv_iss_d;
  logic          mv_pend_q, mv_pend_d;

  logic [FIELD_W-1:0] res_gnt_q, res_gnt_d;
  status_e            res_st_q, res_st_d;

  logic               out_vld_q, out_vld_d;
  logic [FIELD_W-1:0] out_gnt_q, out_gnt_d;
  status_e            out_st_q, out_st_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  alu_op_e       alu_op;
  logic [DW-1:0] alu_a, alu_b, alu_res;
  alu_flags_t    alu_flags;

  logic [DW-1:0] rd_start, rd_len;
  logic          rd_free;
  logic          accept;
  logic          hit;

  assign rd_start = ram_rdata[EW-1:DW+1];
  assign rd_len   = ram_rdata[DW:1];
  assign rd_free  = ram_rdata[0];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  ffsa_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ffsa_alu #(
    .W(DW)
  ) u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .res_o  (alu_res),
    .flags_o(alu_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      ret_q     <= S_IDLE;
      count_q   <= CW'(1);
      scn_vld_q <= 1'b0;
      mv_iss_q  <= 1'b0;
      mv_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      count_q   <= count_d;
      scn_vld_q <= scn_vld_d;
      mv_iss_q  <= mv_iss_d;
      mv_pend_q <= mv_pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    req_q       <= req_d;
    key_q       <= key_d;
    cur_start_q <= cur_start_d;
    cur_len_q   <= cur_len_d;
    idx_q       <= idx_d;
    scn_rd_q    <= scn_rd_d;
    scn_idx_q   <= scn_idx_d;
    mv_rd_q     <= mv_rd_d;
    mv_end_q    <= mv_end_d;
    mv_wa_q     <= mv_wa_d;
    mv_up_q     <= mv_up_d;
    res_gnt_q   <= res_gnt_d;
    res_st_q    <= res_st_d;
    out_gnt_q   <= out_gnt_d;
    out_st_q    <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    kind_d      = kind_q;
    req_d       = req_q;
    key_d       = key_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    idx_d       = idx_q;
    count_d     = count_q;
    scn_rd_d    = scn_rd_q;
    scn_vld_d   = scn_vld_q;
    scn_idx_d   = scn_idx_q;
    mv_rd_d     = mv_rd_q;
    mv_end_d    = mv_end_q;
    mv_wa_d     = mv_wa_q;
    mv_up_d     = mv_up_q;
    mv_iss_d    = mv_iss_q;
    mv_pend_d   = mv_pend_q;
    res_gnt_d   = res_gnt_q;
    res_st_d    = res_st_q;
    out_gnt_d   = out_gnt_q;
    out_st_d    = out_st_q;
    out_vld_d   = out_vld_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    hit       = 1'b0;

    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{DW{1'b0}}, HEAP, 1'b1};
        state_d   = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          kind_d    = kind_e'(kind_i);
          res_gnt_d = '0;
          if (kind_e'(kind_i) == KIND_FREE) begin
            req_d = DW'(release_offset_i);
          end else begin
            req_d = DW'(request_bytes_i);
          end
          if ((kind_e'(kind_i) == KIND_FREE && release_offset_i == '0) ||
              (kind_e'(kind_i) == KIND_ALLOC && request_bytes_i == '0)) begin
            res_st_d = ST_ZERO_OR_NULL;
            state_d  = S_RESULT;
          end else begin
            state_d = S_PREP;
          end
        end
      end

      // search key: request + header, or release offset - header
      S_PREP: begin
        alu_a     = req_q;
        alu_b     = HDR;
        alu_op    = (kind_q == KIND_FREE) ? ALU_SUB : ALU_ADD;
        key_d     = alu_res;
        scn_rd_d  = '0;
        scn_vld_d = 1'b0;
        if (kind_q == KIND_FREE && alu_flags.lt) begin
          res_st_d = ST_UNKNOWN;
          state_d  = S_RESULT;
        end else begin
          state_d = S_SCAN;
        end
      end

      // one read issued per cycle, data checked in the next cycle
      S_SCAN: begin
        ram_raddr = scn_rd_q[IW-1:0];
        scn_rd_d  = scn_rd_q + 1'b1;
        scn_vld_d = (scn_rd_q < count_q);
        scn_idx_d = scn_rd_q[IW-1:0];
        alu_b     = key_q;
        if (kind_q == KIND_FREE) begin
          alu_a = rd_start;
          hit   = scn_vld_q && !rd_free && alu_flags.eq;
        end else begin
          alu_a = rd_len;
          hit   = scn_vld_q && rd_free && alu_flags.gt;
        end
        if (hit) begin
          cur_start_d = rd_start;
          cur_len_d   = rd_len;
          idx_d       = scn_idx_q;
          if (kind_q == KIND_FREE) begin
            state_d = S_F_RNEXT;
          end else if (count_q == MAXC) begin
            res_st_d = ST_TABLE_FULL;
            state_d  = S_RESULT;
          end else if (CW'(scn_idx_q) + 1'b1 < count_q) begin
            // open a slot behind the hit: shift the tail up
            mv_rd_d   = IW'(count_q - 1'b1);
            mv_end_d  = scn_idx_q + 1'b1;
            mv_up_d   = 1'b1;
            mv_iss_d  = 1'b1;
            mv_pend_d = 1'b0;
            ret_d     = S_A_SUB;
            state_d   = S_MOVE;
          end else begin
            state_d = S_A_SUB;
          end
        end else if (scn_vld_q && CW'(scn_idx_q) == count_q - 1'b1) begin
          res_st_d = (kind_q == KIND_FREE) ? ST_UNKNOWN : ST_NO_FIT;
          state_d  = S_RESULT;
        end
      end

      // table shift, pipelined through the registered read port
      S_MOVE: begin
        if (mv_iss_q) begin
          ram_raddr = mv_rd_q;
          mv_pend_d = 1'b1;
          mv_wa_d   = mv_up_q ? mv_rd_q + 1'b1 : mv_rd_q - 1'b1;
          if (mv_rd_q == mv_end_q) begin
            mv_iss_d = 1'b0;
          end else begin
            mv_rd_d = mv_up_q ? mv_rd_q - 1'b1 : mv_rd_q + 1'b1;
          end
        end else begin
          mv_pend_d = 1'b0;
        end
        if (mv_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = mv_wa_q;
          ram_wdata = ram_rdata;
        end
        if (!mv_iss_q && !mv_pend_q) begin
          state_d = ret_q;
        end
      end

      S_A_SUB: begin
        alu_op    = ALU_SUB;
        alu_a     = cur_len_q;
        alu_b     = key_q;
        cur_len_d = alu_res;
        state_d   = S_A_HI;
      end

      // free remainder right behind the allocated part
      S_A_HI: begin
        alu_a     = cur_start_q;
        alu_b     = key_q;
        ram_we    = 1'b1;
        ram_waddr = idx_q + 1'b1;
        ram_wdata = {alu_res, cur_len_q, 1'b1};
        state_d   = S_A_LO;
      end

      S_A_LO: begin
        alu_a     = cur_start_q;
        alu_b     = HDR;
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {cur_start_q, req_q, 1'b0};
        count_d   = count_q + 1'b1;
        res_gnt_d = alu_res[FIELD_W-1:0];
        res_st_d  = ST_OK;
        state_d   = S_RESULT;
      end

      S_F_RNEXT: begin
        if (CW'(idx_q) + 1'b1 < count_q) begin
          ram_raddr = idx_q + 1'b1;
          state_d   = S_F_CNEXT;
        end else begin
          state_d = S_F_RPREV;
        end
      end

      S_F_CNEXT: begin
        alu_a = cur_len_q;
        alu_b = rd_len;
        if (rd_free) begin
          cur_len_d = alu_res;
          state_d   = S_F_HNEXT;
        end else begin
          state_d = S_F_RPREV;
        end
      end

      // absorb the successor, drop its entry
      S_F_HNEXT: begin
        alu_a     = cur_len_q;
        alu_b     = HDR;
        cur_len_d = alu_res;
        count_d   = count_q - 1'b1;
        if (CW'(idx_q) + CW'(2) < count_q) begin
          mv_rd_d   = idx_q + IW'(2);
          mv_end_d  = IW'(count_q - 1'b1);
          mv_up_d   = 1'b0;
          mv_iss_d  = 1'b1;
          mv_pend_d = 1'b0;
          ret_d     = S_F_RPREV;
          state_d   = S_MOVE;
        end else begin
          state_d = S_F_RPREV;
        end
      end

      S_F_RPREV: begin
        if (idx_q != '0) begin
          ram_raddr = idx_q - 1'b1;
          state_d   = S_F_CPREV;
        end else begin
          state_d = S_F_WR;
        end
      end

      S_F_CPREV: begin
        alu_a = cur_len_q;
        alu_b = rd_len;
        if (rd_free) begin
          cur_len_d   = alu_res;
          cur_start_d = rd_start;
          state_d     = S_F_HPREV;
        end else begin
          state_d = S_F_WR;
        end
      end

      // fold into the predecessor, drop the released entry
      S_F_HPREV: begin
        alu_a     = cur_len_q;
        alu_b     = HDR;
        cur_len_d = alu_res;
        count_d   = count_q - 1'b1;
        idx_d     = idx_q - 1'b1;
        if (CW'(idx_q) + 1'b1 < count_q) begin
          mv_rd_d   = idx_q + 1'b1;
          mv_end_d  = IW'(count_q - 1'b1);
          mv_up_d   = 1'b0;
          mv_iss_d  = 1'b1;
          mv_pend_d = 1'b0;
          ret_d     = S_F_WR;
          state_d   = S_MOVE;
        end else begin
          state_d = S_F_WR;
        end
      end

      S_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = {cur_start_q, cur_len_q, 1'b1};
        res_st_d  = ST_OK;
        state_d   = S_RESULT;
      end

      S_RESULT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d = 1'b1;
          out_gnt_d = res_gnt_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_vld_q;
  assign granted_offset_o = out_gnt_q;
  assign status_o         = out_st_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= MAXC))
    else $error("segment count out of range");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("segment count changed while idle");

  a_move_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE && mv_iss_q && mv_pend_q) |-> (mv_rd_q != mv_wa_q))
    else $error("table shift reads the entry it writes");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (granted_offset_o == '0))
    else $error("failed word carries an offset");

endmodule
